// ----- hw/rtl/pal_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pal_pkg
// Types and constants shared by the positional array list engine.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int IN_VALUE_W      = 32;
  localparam int POS_W           = 5;
  localparam int CNT_OUT_W       = 5;
  localparam int ST_W            = 2;
  localparam int QUEUE_DEPTH     = 2;

  typedef enum logic [2:0] {
    OP_APPEND      = 3'd0,
    OP_PUSH_FRONT  = 3'd1,
    OP_INSERT      = 3'd2,
    OP_ERASE       = 3'd3,
    OP_ERASE_VALUE = 3'd4,
    OP_SORT        = 3'd5,
    OP_CLEAR       = 3'd6,
    OP_READ        = 3'd7
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PURGE,
    BK_SORT,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    op_t              op;
    logic [POS_W-1:0] pos;
  } cmd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/pal_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pal_in_if / pal_out_if
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface pal_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic [4:0]         position;
  logic signed [31:0] value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink   (input valid, input operation, input position, input value,
                  output ready);
endinterface

interface pal_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [4:0]         count;
  logic signed [31:0] read_value;

  modport source (output valid, output status, output count, output read_value,
                  input ready);
  modport sink   (input valid, input status, input count, input read_value,
                  output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/pal_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pal_front
// Input stage: takes items, decodes the operation and sizes the value.
// ----------------------------------------------------------------------------
module pal_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  pal_in_if.sink                      in_ch,
  output pal_pkg::cmd_t               cmd,
  output logic [VALUE_WIDTH-1:0]      cmd_val,
  output logic                        push,
  input  wire logic                   q_full
);
  import pal_pkg::*;

  logic                   hold_vld_r, hold_vld_nxt;
  cmd_t                   hold_cmd_r;
  logic [VALUE_WIDTH-1:0] hold_val_r;
  logic                   take;

  assign in_ch.ready = !hold_vld_r || !q_full;
  assign take        = in_ch.valid && in_ch.ready;
  assign push        = hold_vld_r && !q_full;
  assign cmd         = hold_cmd_r;
  assign cmd_val     = hold_val_r;

  always_comb begin
    hold_vld_nxt = hold_vld_r;
    if (take) begin
      hold_vld_nxt = 1'b1;
    end else if (push) begin
      hold_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
    end
  end

  // sign-extend or truncate the q16.16 input to the storage width
  always_ff @(posedge clk) begin
    if (take) begin
      hold_cmd_r.op  <= op_t'(in_ch.operation);
      hold_cmd_r.pos <= in_ch.position;
      hold_val_r     <= VALUE_WIDTH'(in_ch.value);
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/pal_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pal_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module pal_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);
  import pal_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] slot_r [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      fill_r, fill_nxt;

  assign full  = fill_r == (PW+1)'(QUEUE_DEPTH);
  assign empty = fill_r == '0;
  assign dout  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/pal_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pal_back
// Execution stage: holds the element array and count, runs each command
// and drives the result register.
// ----------------------------------------------------------------------------
module pal_back #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_empty,
  input  wire pal_pkg::cmd_t          q_cmd,
  input  wire logic [VALUE_WIDTH-1:0] q_val,
  output logic                        q_pop,
  pal_out_if.source                   out_ch
);
  import pal_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = $clog2(DEPTH);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic [VALUE_WIDTH-1:0] elem_r [DEPTH];
  logic [VALUE_WIDTH-1:0] elem_nxt [DEPTH];
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [CW-1:0]          rem_r, rem_nxt;
  logic [CW-1:0]          step_r, step_nxt;
  logic [VALUE_WIDTH-1:0] key_r;
  bk_state_t              state_r, state_nxt;

  logic                   out_vld_r, out_vld_nxt;
  status_t                out_st_r, out_st_nxt;
  logic [CNT_OUT_W-1:0]   out_cnt_r, out_cnt_nxt;
  logic [IN_VALUE_W-1:0]  out_rd_r, out_rd_nxt;

  logic                   slot_free, take;
  logic [CMPW-1:0]        pos_c, cnt_c, ins_c;
  logic                   full, do_ins, do_del;
  logic                   keep;
  logic [DEPTH-1:0]       swap;

  assign slot_free = !out_vld_r || out_ch.ready;
  assign take      = (state_r == BK_IDLE) && !q_empty && slot_free;
  assign q_pop     = take;

  assign pos_c = CMPW'(q_cmd.pos);
  assign cnt_c = CMPW'(cnt_r);
  assign full  = cnt_r == CW'(DEPTH);
  assign keep  = elem_r[0] != key_r;

  assign out_ch.valid      = out_vld_r;
  assign out_ch.status     = out_st_r;
  assign out_ch.count      = out_cnt_r;
  assign out_ch.read_value = out_rd_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (take && q_cmd.op == OP_ERASE_VALUE) begin
          state_nxt = BK_PURGE;
        end else if (take && q_cmd.op == OP_SORT) begin
          state_nxt = BK_SORT;
        end
      end
      BK_PURGE: begin
        if (rem_r == '0) begin
          state_nxt = BK_DONE;
        end
      end
      BK_SORT: begin
        if (step_r == CW'(DEPTH - 1)) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (slot_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // odd-even transposition pairs, descending by signed value
  always_comb begin
    swap = '0;
    for (int i = 0; i < DEPTH - 1; i++) begin
      swap[i] = (1'(i) == step_r[0]) && (CMPW'(i + 1) < cnt_c) &&
                ($signed(elem_r[i]) < $signed(elem_r[i+1]));
    end
  end

  // datapath and results
  always_comb begin
    elem_nxt    = elem_r;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    step_nxt    = step_r;
    out_vld_nxt = out_vld_r;
    out_st_nxt  = out_st_r;
    out_cnt_nxt = out_cnt_r;
    out_rd_nxt  = out_rd_r;
    ins_c       = pos_c;
    do_ins      = 1'b0;
    do_del      = 1'b0;

    if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      BK_IDLE: begin
        if (take) begin
          out_st_nxt = ST_OK;
          out_rd_nxt = '0;
          case (q_cmd.op)
            OP_APPEND: begin
              ins_c = cnt_c;
              if (full) out_st_nxt = ST_FULL;
              else      do_ins = 1'b1;
            end
            OP_PUSH_FRONT: begin
              ins_c = '0;
              if (full) out_st_nxt = ST_FULL;
              else      do_ins = 1'b1;
            end
            OP_INSERT: begin
              if (pos_c > cnt_c) out_st_nxt = ST_BADPOS;
              else if (full)     out_st_nxt = ST_FULL;
              else               do_ins = 1'b1;
            end
            OP_ERASE: begin
              if (pos_c >= cnt_c) out_st_nxt = ST_BADPOS;
              else                do_del = 1'b1;
            end
            OP_ERASE_VALUE: begin
              rem_nxt = cnt_r;
            end
            OP_SORT: begin
              step_nxt = '0;
            end
            OP_CLEAR: begin
              cnt_nxt = '0;
            end
            OP_READ: begin
              if (pos_c >= cnt_c) begin
                out_st_nxt = ST_BADPOS;
              end else begin
                out_rd_nxt = IN_VALUE_W'(elem_r[pos_c[IW-1:0]]);
              end
            end
            default: ;
          endcase

          if (do_ins) begin
            for (int i = 0; i < DEPTH; i++) begin
              if (CMPW'(i) > ins_c) begin
                elem_nxt[i] = elem_r[(i > 0) ? i - 1 : 0];
              end else if (CMPW'(i) == ins_c) begin
                elem_nxt[i] = q_val;
              end
            end
            cnt_nxt = cnt_r + 1'b1;
          end
          if (do_del) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
              if (CMPW'(i) >= pos_c) begin
                elem_nxt[i] = elem_r[i+1];
              end
            end
            cnt_nxt = cnt_r - 1'b1;
          end

          if (q_cmd.op != OP_ERASE_VALUE && q_cmd.op != OP_SORT) begin
            out_vld_nxt = 1'b1;
            out_cnt_nxt = CNT_OUT_W'(cnt_nxt);
          end
        end
      end
      BK_PURGE: begin
        // head leaves the front; kept heads rejoin at the tail of the kept run
        if (rem_r != '0) begin
          for (int i = 0; i < DEPTH; i++) begin
            if (keep && CW'(i) == cnt_r - 1'b1) begin
              elem_nxt[i] = elem_r[0];
            end else if (i < DEPTH - 1) begin
              elem_nxt[i] = elem_r[(i < DEPTH - 1) ? i + 1 : i];
            end
          end
          if (!keep) begin
            cnt_nxt = cnt_r - 1'b1;
          end
          rem_nxt = rem_r - 1'b1;
        end
      end
      BK_SORT: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (i < DEPTH - 1 && swap[i]) begin
            elem_nxt[i] = elem_r[(i < DEPTH - 1) ? i + 1 : i];
          end else if (i > 0 && swap[(i > 0) ? i - 1 : 0]) begin
            elem_nxt[i] = elem_r[(i > 0) ? i - 1 : 0];
          end
        end
        step_nxt = step_r + 1'b1;
      end
      BK_DONE: begin
        if (slot_free) begin
          out_vld_nxt = 1'b1;
          out_st_nxt  = ST_OK;
          out_cnt_nxt = CNT_OUT_W'(cnt_r);
          out_rd_nxt  = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    elem_r    <= elem_nxt;
    rem_r     <= rem_nxt;
    step_r    <= step_nxt;
    out_st_r  <= out_st_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_rd_r  <= out_rd_nxt;
    if (take) begin
      key_r <= q_val;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/positional_array_list_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_array_list_engine
// Ordered array of signed q16.16 values with push, insert, erase, erase by
// value, descending sort, clear and read.
// ----------------------------------------------------------------------------
// An item passes an input register and a two-entry command queue, then the
// execution stage runs it. Push, insert, erase, clear and read finish in the
// execution stage as soon as they issue; erase by value visits each element
// in turn and then makes a final check before its result, and sort runs
// DEPTH rounds of odd-even compare-exchange across the array before its
// result. One result comes back per item, in order; a full array or a bad
// position is reported in status and leaves the array unchanged.
module positional_array_list_engine #(
  parameter int DEPTH       = pal_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = pal_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pal_in_if.sink    in_ch,
  pal_out_if.source out_ch
);
  import pal_pkg::*;

  localparam int QW = $bits(cmd_t) + VALUE_WIDTH;

  cmd_t                   f_cmd, q_cmd;
  logic [VALUE_WIDTH-1:0] f_val, q_val;
  logic                   f_push, q_full, q_pop, q_empty;
  logic [QW-1:0]          q_dout;

  pal_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cmd    (f_cmd),
    .cmd_val(f_val),
    .push   (f_push),
    .q_full (q_full)
  );

  pal_queue #(.WIDTH(QW)) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (f_push),
    .din  ({f_cmd, f_val}),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_dout),
    .empty(q_empty)
  );

  assign q_cmd = q_dout[QW-1:VALUE_WIDTH];
  assign q_val = q_dout[VALUE_WIDTH-1:0];

  pal_back #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_empty(q_empty),
    .q_cmd  (q_cmd),
    .q_val  (q_val),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire
